// File: sv/css_pkg.sv
// Shared types and codes for the capacity split stack set.
// Used by the controller, the datapath and the top level; depends on nothing.
package css_pkg;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 5;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_PUSH     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP_LAST = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_AT   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch_new;
    logic open;
  } cmd_t;

  typedef struct packed {
    logic need_open;
  } sts_t;

endpackage

// File: sv/css_ctrl.sv
// Controller state machine of the capacity split stack set.
// Sequences accept, execute and sub-stack open; owns the output valid.
// Depends on css_pkg.
module css_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  css_pkg::sts_t sts_i,
  output css_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OPEN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.need_open) begin
          cmd_o.fetch_new = 1'b1;
          state_d         = S_OPEN;
        end else if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_OPEN: begin
        if (out_free) begin
          cmd_o.open = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.exec || cmd_o.open) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/css_dp.sv
// Datapath of the capacity split stack set: plate memory, fill counts,
// position-to-row map, capacity register and result registers. Depends on css_pkg.
module css_dp #(
  parameter int MAX_STACKS   = 16,
  parameter int MAX_CAPACITY = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [css_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [css_pkg::FUNC_W-1:0]     func_i,
  input  logic [DATA_WIDTH-1:0]          push_value_i,
  input  logic [css_pkg::INDEX_W-1:0]    stack_index_i,
  input  css_pkg::cmd_t                  cmd_i,
  output css_pkg::sts_t                  sts_o,
  output logic [DATA_WIDTH-1:0]          pop_value_o,
  output logic [css_pkg::STATUS_W-1:0]   status_o,
  output logic [css_pkg::USED_W-1:0]     stacks_used_o
);

  localparam int PW    = $clog2(MAX_STACKS);
  localparam int UW    = $clog2(MAX_STACKS + 1);
  localparam int FW    = $clog2(MAX_CAPACITY + 1);
  localparam int DEPTH = MAX_STACKS * MAX_CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = UW + css_pkg::INDEX_W;

  logic [css_pkg::CFG_W-1:0]   cfg_q;
  logic [FW-1:0]               cap;
  logic [UW-1:0]               used_q, used_d;
  logic [FW-1:0]               fill_q [MAX_STACKS];
  logic [FW-1:0]               fill_d [MAX_STACKS];
  logic [PW-1:0]               order_q [MAX_STACKS];
  logic [PW-1:0]               order_d [MAX_STACKS];
  logic [PW-1:0]               order_up [MAX_STACKS];
  logic [css_pkg::FUNC_W-1:0]  func_q;
  logic [DATA_WIDTH-1:0]       value_q;
  logic [css_pkg::INDEX_W-1:0] idx_q;
  logic [PW-1:0]               pos_q;
  logic [PW-1:0]               row_q;
  logic [PW-1:0]               rd_pos;
  logic [FW-1:0]               fill_row;
  logic                        row_full;
  logic                        bad_idx;
  logic                        remove;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               addr;
  logic [FW-1:0]               col;
  logic [DATA_WIDTH-1:0]       mem_q [DEPTH];
  logic [DATA_WIDTH-1:0]       rdata_q;
  logic [css_pkg::STATUS_W-1:0] status_d, status_q;
  logic                        pop_ok_d, pop_ok_q;
  logic [css_pkg::USED_W-1:0]  out_used_q;

  always_comb begin
    if (cfg_q == '0) begin
      cap = FW'(1);
    end else if (32'(cfg_q) > MAX_CAPACITY) begin
      cap = FW'(MAX_CAPACITY);
    end else begin
      cap = FW'(cfg_q);
    end
  end

  assign fill_row = fill_q[row_q];
  assign row_full = (fill_row >= cap);
  assign bad_idx  = (XW'(idx_q) >= XW'(used_q));
  assign sts_o.need_open = (func_q == css_pkg::FUNC_PUSH) && row_full &&
                           (used_q < UW'(MAX_STACKS));

  always_comb begin
    if (cmd_i.fetch_new) begin
      rd_pos = PW'(used_q);
    end else if (func_i == css_pkg::FUNC_POP_AT) begin
      rd_pos = PW'(stack_index_i);
    end else begin
      rd_pos = PW'(used_q - UW'(1));
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STACKS - 1; i++) order_up[i] = order_q[i + 1];
    order_up[MAX_STACKS-1] = order_q[MAX_STACKS-1];
  end

  always_comb begin
    used_d   = used_q;
    fill_d   = fill_q;
    order_d  = order_q;
    status_d = css_pkg::ST_OK;
    pop_ok_d = 1'b0;
    remove   = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    col      = fill_row;
    if (cmd_i.open) begin
      mem_we         = 1'b1;
      col            = '0;
      fill_d[row_q]  = FW'(1);
      used_d         = used_q + UW'(1);
    end else if (cmd_i.exec) begin
      unique case (func_q)
        css_pkg::FUNC_PUSH: begin
          if (row_full) begin
            status_d = css_pkg::ST_FULL;
          end else begin
            mem_we        = 1'b1;
            fill_d[row_q] = fill_row + FW'(1);
          end
        end
        css_pkg::FUNC_POP_LAST, css_pkg::FUNC_POP_AT: begin
          if (func_q == css_pkg::FUNC_POP_AT && bad_idx) begin
            status_d = css_pkg::ST_BADIDX;
          end else if (fill_row == '0) begin
            status_d = css_pkg::ST_EMPTY;
          end else begin
            mem_re        = 1'b1;
            pop_ok_d      = 1'b1;
            col           = fill_row - FW'(1);
            fill_d[row_q] = fill_row - FW'(1);
            remove        = (fill_row == FW'(1)) && (used_q > UW'(1));
          end
        end
        default: status_d = css_pkg::ST_OK;
      endcase
      if (remove) begin
        used_d = used_q - UW'(1);
        for (int i = 0; i < MAX_STACKS; i++) begin
          if (UW'(i) < UW'(pos_q) || UW'(i) >= used_q) begin
            order_d[i] = order_q[i];
          end else if (UW'(i) == used_q - UW'(1)) begin
            order_d[i] = row_q;
          end else begin
            order_d[i] = order_up[i];
          end
        end
      end
    end
  end

  assign addr = AW'(row_q) * AW'(MAX_CAPACITY) + AW'(col);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr] <= value_q;
    if (mem_re) rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= push_value_i;
      idx_q   <= stack_index_i;
      pos_q   <= rd_pos;
    end
    if (cmd_i.load || cmd_i.fetch_new) row_q <= order_q[rd_pos];
    if (cmd_i.exec || cmd_i.open) begin
      status_q   <= status_d;
      pop_ok_q   <= pop_ok_d;
      out_used_q <= css_pkg::USED_W'(used_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= css_pkg::CAP_RESET;
      used_q <= UW'(1);
      for (int i = 0; i < MAX_STACKS; i++) begin
        fill_q[i]  <= '0;
        order_q[i] <= PW'(i);
      end
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      used_q  <= used_d;
      fill_q  <= fill_d;
      order_q <= order_d;
    end
  end

  assign pop_value_o   = pop_ok_q ? rdata_q : '0;
  assign status_o      = status_q;
  assign stacks_used_o = out_used_q;

endmodule

// File: sv/capacity_split_stack_set.sv
// Capacity split stack set top level: stream ports around css_ctrl and css_dp.
// The result is registered on execute, or on open when a push opens a sub-stack;
// output stalls delay it. The accept/execute sequence around the single plate
// memory port and fill lookup takes a new item only once the last has executed.
// Reset (asynchronous, active low): one empty sub-stack, identity row map,
// capacity 16; the plate memory is not cleared.
module capacity_split_stack_set #(
  parameter int MAX_STACKS   = 16,
  parameter int MAX_CAPACITY = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [css_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // push_value, stack_index
  input  logic [((DATA_WIDTH+4+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [css_pkg::FUNC_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pop_value, status, stacks_used
  output logic [((DATA_WIDTH+7+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_W = ((DATA_WIDTH + 7 + 7) / 8) * 8;

  css_pkg::cmd_t                 cmd;
  css_pkg::sts_t                 sts;
  logic [DATA_WIDTH-1:0]         pop_value;
  logic [css_pkg::STATUS_W-1:0]  status;
  logic [css_pkg::USED_W-1:0]    stacks_used;

  css_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  css_dp #(
    .MAX_STACKS   (MAX_STACKS),
    .MAX_CAPACITY (MAX_CAPACITY),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (s_axis_tuser),
    .push_value_i  (s_axis_tdata[DATA_WIDTH-1:0]),
    .stack_index_i (s_axis_tdata[DATA_WIDTH+css_pkg::INDEX_W-1:DATA_WIDTH]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pop_value_o   (pop_value),
    .status_o      (status),
    .stacks_used_o (stacks_used)
  );

  assign m_axis_tdata = OUT_W'({stacks_used, status, pop_value});

endmodule

// File: sv/css_checker.sv
// Port-level checks for the capacity split stack set, bound to the top level.
// Depends on css_pkg and on the top level's port names.
module css_checker #(
  parameter int MAX_STACKS = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((DATA_WIDTH+7+7)/8)*8-1:0] m_axis_tdata
);

  logic [DATA_WIDTH-1:0]        pop_value;
  logic [css_pkg::STATUS_W-1:0] status;
  logic [css_pkg::USED_W-1:0]   stacks_used;

  assign pop_value   = m_axis_tdata[DATA_WIDTH-1:0];
  assign status      = m_axis_tdata[DATA_WIDTH+css_pkg::STATUS_W-1:DATA_WIDTH];
  assign stacks_used = m_axis_tdata[DATA_WIDTH+css_pkg::STATUS_W+css_pkg::USED_W-1:
                                    DATA_WIDTH+css_pkg::STATUS_W];

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (MAX_STACKS < 32) |-> stacks_used != '0)
    else $error("no sub-stack in use");

  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != css_pkg::ST_OK |-> pop_value == '0)
    else $error("failed operation returned data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind capacity_split_stack_set css_checker #(
  .MAX_STACKS (MAX_STACKS),
  .DATA_WIDTH (DATA_WIDTH)
) u_css_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/tb.sv
// Self-checking testbench for capacity_split_stack_set: directed and random push/pop traffic
// with random stalls on both stream sides, checked against an in-bench stack set predictor.
// Depends on css_pkg and capacity_split_stack_set.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_STACKS   = 16;
  localparam int MAX_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int IN_W         = ((DATA_W + 4 + 7) / 8) * 8;
  localparam int OUT_W        = ((DATA_W + 7 + 7) / 8) * 8;
  localparam int USED_LSB     = DATA_W + css_pkg::STATUS_W;

  localparam logic [css_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0]            value;
    logic [css_pkg::STATUS_W-1:0] status;
    logic [css_pkg::USED_W-1:0]   used;
  } stack_result_t;

  class plate_tracker;
    logic [DATA_W-1:0]           plates[MAX_STACKS][MAX_CAPACITY];
    logic [css_pkg::USED_W-1:0]  fill[MAX_STACKS];
    logic [css_pkg::INDEX_W-1:0] order[MAX_STACKS];
    int unsigned                 in_use;
    logic [css_pkg::CFG_W-1:0]   cap_reg;
    stack_result_t               pending[$];
    int unsigned                 errors;

    function new();
      for (int i = 0; i < MAX_STACKS; i++) begin
        fill[i]  = '0;
        order[i] = css_pkg::INDEX_W'(i);
      end
      in_use  = 1;
      cap_reg = css_pkg::CAP_RESET;
      errors  = 0;
    endfunction

    function int unsigned cap_limit();
      int unsigned c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > MAX_CAPACITY) c = MAX_CAPACITY;
      return c;
    endfunction

    function logic [css_pkg::STATUS_W-1:0] take_from(int unsigned pos,
                                                     output logic [DATA_W-1:0] val);
      int unsigned                 row;
      int unsigned                 f;
      logic [css_pkg::INDEX_W-1:0] freed;
      val = '0;
      row = order[pos];
      f   = fill[row];
      if (f == 0) return css_pkg::ST_EMPTY;
      f--;
      val       = plates[row][f];
      fill[row] = css_pkg::USED_W'(f);
      if (f == 0 && in_use > 1) begin
        freed = order[pos];
        for (int i = pos; i + 1 < in_use; i++) order[i] = order[i+1];
        order[in_use-1] = freed;
        in_use--;
      end
      return css_pkg::ST_OK;
    endfunction

    function void note_request(logic [css_pkg::FUNC_W-1:0] func, logic [DATA_W-1:0] value,
                               logic [css_pkg::INDEX_W-1:0] index);
      stack_result_t res;
      int unsigned   row;
      res.value  = '0;
      res.status = css_pkg::ST_OK;
      unique case (func)
        css_pkg::FUNC_PUSH: begin
          row = order[in_use-1];
          if (fill[row] >= cap_limit()) begin
            if (in_use >= MAX_STACKS) begin
              res.status = css_pkg::ST_FULL;
            end else begin
              in_use++;
              row       = order[in_use-1];
              fill[row] = '0;
            end
          end
          if (res.status == css_pkg::ST_OK) begin
            plates[row][fill[row][3:0]] = value;
            fill[row]++;
          end
        end
        css_pkg::FUNC_POP_LAST: res.status = take_from(in_use - 1, res.value);
        css_pkg::FUNC_POP_AT: begin
          if (index >= in_use) res.status = css_pkg::ST_BADIDX;
          else res.status = take_from(index, res.value);
        end
        default: ;
      endcase
      res.used = css_pkg::USED_W'(in_use);
      pending = {pending, res};
    endfunction

    function void check_response(logic [OUT_W-1:0] d);
      stack_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer 0x%0h", d);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (d[DATA_W-1:0] !== want.value) begin
        $error("pop_value: expected %0d, got %0d", $signed(want.value), $signed(d[DATA_W-1:0]));
        errors++;
      end
      if (d[DATA_W+:css_pkg::STATUS_W] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status,
               d[DATA_W+:css_pkg::STATUS_W]);
        errors++;
      end
      if (d[USED_LSB+:css_pkg::USED_W] !== want.used) begin
        $error("stacks_used: expected %0d, got %0d", want.used,
               d[USED_LSB+:css_pkg::USED_W]);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic [css_pkg::CFG_W-1:0]   cfg_wdata_i   = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [IN_W-1:0]             s_axis_tdata  = '0;
  logic [css_pkg::FUNC_W-1:0]  s_axis_tuser  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [OUT_W-1:0]            m_axis_tdata;
  logic                        steady        = 1'b0;
  plate_tracker                sb;

  capacity_split_stack_set i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
  end

  task automatic issue_op(logic [css_pkg::FUNC_W-1:0] func, logic [DATA_W-1:0] value,
                          logic [css_pkg::INDEX_W-1:0] index);
    while (!steady && $urandom_range(0, 99) < 10) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(IN_W - DATA_W - css_pkg::INDEX_W){1'b0}}, index, value};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(func, value, index);
  endtask

  task automatic set_capacity(logic [css_pkg::CFG_W-1:0] cap);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    sb.cap_reg   = cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_op(int unsigned push_pct);
    int unsigned                 r;
    logic [css_pkg::FUNC_W-1:0]  func;
    logic [css_pkg::INDEX_W-1:0] index;
    r     = $urandom_range(0, 99);
    index = css_pkg::INDEX_W'($urandom_range(0, MAX_STACKS - 1));
    if (r < 3) func = FUNC_NONE;
    else if (r < 3 + push_pct * 97 / 100) func = css_pkg::FUNC_PUSH;
    else if (r[0]) func = css_pkg::FUNC_POP_LAST;
    else begin
      func = css_pkg::FUNC_POP_AT;
      if ($urandom_range(0, 99) < 85) begin
        index = css_pkg::INDEX_W'($urandom_range(0, sb.in_use - 1));
      end
    end
    issue_op(func, $urandom, index);
  endtask

  initial begin
    logic [css_pkg::CFG_W-1:0] caps[8] = '{5'd31, 5'd1, 5'd5, 5'd0, 5'd16, 5'd3, 5'd2, 5'd12};
    int unsigned               push_pct;
    int unsigned               count;
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_capacity(5'd2);
    issue_op(css_pkg::FUNC_POP_LAST, 32'h1234_5678, 4'd0);
    issue_op(css_pkg::FUNC_POP_AT,   32'h0,         4'd0);
    issue_op(css_pkg::FUNC_POP_AT,   32'hFFFF_FFFF, 4'd15);
    issue_op(FUNC_NONE,              32'hDEAD_BEEF, 4'd9);
    issue_op(css_pkg::FUNC_PUSH,     32'h7FFF_FFFF, 4'd0);
    issue_op(css_pkg::FUNC_PUSH,     32'h8000_0000, 4'd15);
    issue_op(css_pkg::FUNC_PUSH,     32'h0000_0000, 4'd3);
    issue_op(css_pkg::FUNC_POP_AT,   32'h0,         4'd0);
    issue_op(css_pkg::FUNC_POP_AT,   32'h0,         4'd3);
    issue_op(css_pkg::FUNC_POP_AT,   32'h0,         4'd0);
    issue_op(css_pkg::FUNC_POP_LAST, 32'h0,         4'd0);
    issue_op(css_pkg::FUNC_POP_LAST, 32'h0,         4'd0);
    issue_op(css_pkg::FUNC_PUSH,     32'hFFFF_FFFF, 4'd0);
    issue_op(css_pkg::FUNC_PUSH,     32'h5A5A_A5A5, 4'd0);

    set_capacity(5'd0);
    for (int i = 0; i < MAX_STACKS; i++) issue_op(css_pkg::FUNC_PUSH, $urandom, 4'd0);

    count = 0;
    foreach (caps[p]) begin
      set_capacity(p == 7 ? css_pkg::CFG_W'($urandom_range(0, 31)) : caps[p]);
      for (int i = 0; i < 210; i++) begin
        if (i % 30 == 0) begin
          case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        steady = (count >= 500 && count < 800);
        random_op(push_pct);
        count++;
      end
    end
    steady = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/css_pkg.sv
sv/css_ctrl.sv
sv/css_dp.sv
sv/capacity_split_stack_set.sv
sv/css_checker.sv
dv/tb.sv
